// ===== hw/rtl/flash_eeprom_emulation_defines.svh =====
// Assertion macros shared by the flash EEPROM emulation RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef FLASH_EEPROM_EMULATION_DEFINES_SVH
`define FLASH_EEPROM_EMULATION_DEFINES_SVH

// Checked on every clock edge outside reset.
`define FEE_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define FEE_ASSERT_ANY(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== hw/rtl/fee_pkg.sv =====
// Package for the flash EEPROM emulation: sizes, codes and the
// command/status structs between controller and datapath. No dependencies.
package fee_pkg;

  localparam int ENTRIES     = 64;
  localparam int PART_WORDS  = 256;
  localparam int STORE_WORDS = 2 * PART_WORDS;
  localparam int STORE_AW    = $clog2(STORE_WORDS);
  localparam int PW_AW       = $clog2(PART_WORDS);
  localparam int CA_W        = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W       = STORE_AW + 1;
  // Records that would fall past the last word of a partition are dropped.
  localparam int NCOPY       = (ENTRIES < PART_WORDS - 1) ? ENTRIES : PART_WORDS - 1;

  localparam logic [31:0] ERASED_WORD = 32'hffff_ffff;
  localparam logic [31:0] MARK_RESET  = 32'h5555_5555;

  typedef enum logic [1:0] {
    MODE_INIT   = 2'd0,
    MODE_READ   = 2'd1,
    MODE_WRITE  = 2'd2,
    MODE_FORMAT = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    FS_ERASED = 2'd0,
    FS_MARK   = 2'd1,
    FS_CACHE  = 2'd2,
    FS_ITEM   = 2'd3
  } fsrc_e;

  typedef struct packed {
    logic                load_item;
    logic                f_re;
    logic [STORE_AW-1:0] f_raddr;
    logic                f_we;
    logic [STORE_AW-1:0] f_waddr;
    fsrc_e               f_src;
    logic [CA_W-1:0]     rec_idx;
    logic                c_re;
    logic [CA_W-1:0]     c_raddr;
    logic                c_we;
    logic [CA_W-1:0]     c_waddr;
    logic                c_from_flash;
    logic                c_clr;
    logic                set_valid;
    logic                set_part;
    logic                part_val;
    logic                res_ld;
    logic                res_err;
    logic                res_rd;
  } cmd_t;

  typedef struct packed {
    mode_e           mode;
    logic            addr_ok;
    logic [CA_W-1:0] addr_idx;
    logic            cache_eq;
    logic            frd_erased;
    logic            frd_mark;
    logic            frd_idx_ok;
    logic [CA_W-1:0] frd_idx;
    logic            part;
    logic            part_valid;
  } sts_t;

  // Flash word address of an offset within a partition.
  function automatic logic [STORE_AW-1:0] fee_addr(input logic p,
                                                   input logic [PW_AW-1:0] off);
    logic [STORE_AW-1:0] base;
    base = p ? STORE_AW'(PART_WORDS) : '0;
    return base + STORE_AW'(off);
  endfunction

endpackage

// ===== hw/rtl/fee_datapath.sv =====
// Datapath of the flash EEPROM emulation: flash store, value cache,
// item and result registers. Depends on fee_pkg.
module fee_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [1:0]          mode_i,
  input  logic [15:0]         address_i,
  input  logic [15:0]         write_data_i,
  input  logic                cfg_we_i,
  input  logic [31:0]         cfg_wdata_i,
  input  fee_pkg::cmd_t       cmd_i,
  output fee_pkg::sts_t       sts_o,
  output logic [15:0]         read_data_o,
  output logic                status_o
);

  logic [31:0] flash_mem [fee_pkg::STORE_WORDS];
  logic [15:0] cache_mem [fee_pkg::ENTRIES];

  logic [fee_pkg::ENTRIES-1:0] cvld_q;
  logic                        part_q, pvld_q;
  logic [31:0]                 mark_q;
  fee_pkg::mode_e              mode_q;
  logic [15:0]                 addr_q, data_q;
  logic [31:0]                 frd_q;
  logic [15:0]                 crd_q;
  logic [15:0]                 rd_q;
  logic                        st_q;
  logic [31:0]                 fwdata;
  logic [15:0]                 cwdata;

  always_comb begin
    unique case (cmd_i.f_src)
      fee_pkg::FS_ERASED: fwdata = fee_pkg::ERASED_WORD;
      fee_pkg::FS_MARK:   fwdata = mark_q;
      fee_pkg::FS_CACHE:  fwdata = {16'(cmd_i.rec_idx), crd_q};
      fee_pkg::FS_ITEM:   fwdata = {addr_q, data_q};
      default:            fwdata = fee_pkg::ERASED_WORD;
    endcase
  end

  assign cwdata = cmd_i.c_from_flash ? frd_q[15:0] : data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cvld_q <= '0;
      part_q <= 1'b0;
      pvld_q <= 1'b0;
      mark_q <= fee_pkg::MARK_RESET;
    end else begin
      if (cfg_we_i) mark_q <= cfg_wdata_i;
      if (cmd_i.c_clr) cvld_q <= '0;
      else if (cmd_i.c_we) cvld_q[cmd_i.c_waddr] <= 1'b1;
      if (cmd_i.set_part) part_q <= cmd_i.part_val;
      if (cmd_i.set_valid) pvld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      mode_q <= fee_pkg::mode_e'(mode_i);
      addr_q <= address_i;
      data_q <= write_data_i;
    end
    if (cmd_i.f_we) flash_mem[cmd_i.f_waddr] <= fwdata;
    if (cmd_i.f_re) frd_q <= flash_mem[cmd_i.f_raddr];
    if (cmd_i.c_we) cache_mem[cmd_i.c_waddr] <= cwdata;
    if (cmd_i.c_re) crd_q <= cvld_q[cmd_i.c_raddr] ? cache_mem[cmd_i.c_raddr] : 16'h0;
    if (cmd_i.res_ld) begin
      rd_q <= cmd_i.res_rd ? crd_q : 16'h0;
      st_q <= cmd_i.res_err;
    end
  end

  always_comb begin
    sts_o.mode       = mode_q;
    sts_o.addr_ok    = addr_q < 16'(fee_pkg::ENTRIES);
    sts_o.addr_idx   = addr_q[fee_pkg::CA_W-1:0];
    sts_o.cache_eq   = crd_q == data_q;
    sts_o.frd_erased = frd_q == fee_pkg::ERASED_WORD;
    sts_o.frd_mark   = frd_q == mark_q;
    sts_o.frd_idx_ok = frd_q[31:16] < 16'(fee_pkg::ENTRIES);
    sts_o.frd_idx    = frd_q[16 +: fee_pkg::CA_W];
    sts_o.part       = part_q;
    sts_o.part_valid = pvld_q;
  end

  assign read_data_o = rd_q;
  assign status_o    = st_q;

endmodule

// ===== hw/rtl/fee_ctrl.sv =====
// Controller of the flash EEPROM emulation: sequencer for the clearing
// pass, init, read, write, compaction and format. Depends on fee_pkg and flash_eeprom_emulation_defines.svh.
`include "flash_eeprom_emulation_defines.svh"

module fee_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  fee_pkg::sts_t sts_i,
  output fee_pkg::cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DISPATCH, S_CHK0, S_CHK1, S_ERASE, S_COPY_RD, S_COPY_WR,
    S_MARK, S_SCAN, S_WIPE, S_RWAIT, S_WCMP, S_WLAST, S_BSCAN, S_FIN
  } state_e;

  typedef enum logic [1:0] {
    OP_INIT, OP_FORMAT, OP_COMPACT
  } op_e;

  state_e                      state_q, state_d;
  op_e                         op_q, op_d;
  logic [fee_pkg::CNT_W-1:0]   cnt_q, cnt_d;
  logic [fee_pkg::PW_AW-1:0]   poff_q, poff_d;
  logic                        tgt_q, tgt_d, pend_q, pend_d;
  logic                        err_q, err_d, rdsel_q, rdsel_d, ov_q, ov_d;
  logic                        issue;
  logic [fee_pkg::PW_AW-1:0]   cnt_off;

  assign cnt_off = cnt_q[fee_pkg::PW_AW-1:0];

  always_comb begin
    state_d = state_q; op_d = op_q; cnt_d = cnt_q; poff_d = poff_q;
    tgt_d = tgt_q; pend_d = pend_q; err_d = err_q; rdsel_d = rdsel_q;
    ov_d = ov_q & ~out_ready_i;
    cmd_o = '0;
    in_ready_o = 1'b0;
    issue = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.f_we = 1'b1;
        cmd_o.f_waddr = cnt_q[fee_pkg::STORE_AW-1:0];
        cmd_o.f_src = fee_pkg::FS_ERASED;
        if (cnt_q == fee_pkg::CNT_W'(fee_pkg::STORE_WORDS - 1)) begin
          cnt_d = '0;
          state_d = S_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        err_d = 1'b0;
        rdsel_d = 1'b0;
        unique case (sts_i.mode)
          fee_pkg::MODE_INIT: begin
            cmd_o.f_re = 1'b1;
            cmd_o.f_raddr = fee_pkg::fee_addr(1'b0, '0);
            op_d = OP_INIT;
            state_d = S_CHK0;
          end
          fee_pkg::MODE_READ: begin
            if (sts_i.addr_ok) begin
              cmd_o.c_re = 1'b1;
              cmd_o.c_raddr = sts_i.addr_idx;
              rdsel_d = 1'b1;
              state_d = S_RWAIT;
            end else begin
              err_d = 1'b1;
              state_d = S_FIN;
            end
          end
          fee_pkg::MODE_WRITE: begin
            if (sts_i.part_valid && sts_i.addr_ok) begin
              cmd_o.c_re = 1'b1;
              cmd_o.c_raddr = sts_i.addr_idx;
              state_d = S_WCMP;
            end else begin
              err_d = 1'b1;
              state_d = S_FIN;
            end
          end
          fee_pkg::MODE_FORMAT: begin
            cmd_o.c_clr = 1'b1;
            cmd_o.set_part = 1'b1;
            cmd_o.part_val = 1'b0;
            cmd_o.set_valid = 1'b1;
            op_d = OP_FORMAT;
            tgt_d = 1'b0;
            cnt_d = '0;
            state_d = S_ERASE;
          end
          default: state_d = S_FIN;
        endcase
      end
      S_CHK0: begin
        if (sts_i.frd_mark) begin
          cmd_o.set_part = 1'b1;
          cmd_o.part_val = 1'b0;
          cmd_o.set_valid = 1'b1;
          cnt_d = fee_pkg::CNT_W'(1);
          pend_d = 1'b0;
          state_d = S_SCAN;
        end else begin
          cmd_o.f_re = 1'b1;
          cmd_o.f_raddr = fee_pkg::fee_addr(1'b1, '0);
          state_d = S_CHK1;
        end
      end
      S_CHK1: begin
        cmd_o.set_part = 1'b1;
        cmd_o.set_valid = 1'b1;
        if (sts_i.frd_mark) begin
          cmd_o.part_val = 1'b1;
          cnt_d = fee_pkg::CNT_W'(1);
          pend_d = 1'b0;
          state_d = S_SCAN;
        end else begin
          cmd_o.part_val = 1'b0;
          tgt_d = 1'b0;
          cnt_d = '0;
          state_d = S_ERASE;
        end
      end
      S_ERASE: begin
        cmd_o.f_we = 1'b1;
        cmd_o.f_waddr = fee_pkg::fee_addr(tgt_q, cnt_off);
        cmd_o.f_src = fee_pkg::FS_ERASED;
        if (cnt_q == fee_pkg::CNT_W'(fee_pkg::PART_WORDS - 1)) begin
          cnt_d = '0;
          state_d = S_COPY_RD;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_COPY_RD: begin
        cmd_o.c_re = 1'b1;
        cmd_o.c_raddr = cnt_q[fee_pkg::CA_W-1:0];
        state_d = S_COPY_WR;
      end
      S_COPY_WR: begin
        cmd_o.f_we = 1'b1;
        cmd_o.f_waddr = fee_pkg::fee_addr(tgt_q, fee_pkg::PW_AW'(cnt_q + 1'b1));
        cmd_o.f_src = fee_pkg::FS_CACHE;
        cmd_o.rec_idx = cnt_q[fee_pkg::CA_W-1:0];
        if (cnt_q == fee_pkg::CNT_W'(fee_pkg::NCOPY - 1)) begin
          state_d = S_MARK;
        end else begin
          cnt_d = cnt_q + 1'b1;
          state_d = S_COPY_RD;
        end
      end
      S_MARK: begin
        cmd_o.f_we = 1'b1;
        cmd_o.f_waddr = fee_pkg::fee_addr(tgt_q, '0);
        cmd_o.f_src = fee_pkg::FS_MARK;
        unique case (op_q)
          OP_INIT: begin
            cnt_d = fee_pkg::CNT_W'(1);
            pend_d = 1'b0;
            state_d = S_SCAN;
          end
          OP_FORMAT: begin
            tgt_d = 1'b1;
            cnt_d = '0;
            state_d = S_WIPE;
          end
          OP_COMPACT: begin
            cmd_o.set_part = 1'b1;
            cmd_o.part_val = tgt_q;
            tgt_d = ~tgt_q;
            cnt_d = '0;
            state_d = S_WIPE;
          end
          default: state_d = S_FIN;
        endcase
      end
      S_SCAN: begin
        // Forward pass: a later record overwrites an earlier one, so the
        // newest record of each index ends up in the cache.
        issue = cnt_q < fee_pkg::CNT_W'(fee_pkg::PART_WORDS);
        if (issue) begin
          cmd_o.f_re = 1'b1;
          cmd_o.f_raddr = fee_pkg::fee_addr(sts_i.part, cnt_off);
          cnt_d = cnt_q + 1'b1;
        end
        pend_d = issue;
        if (pend_q && sts_i.frd_idx_ok) begin
          cmd_o.c_we = 1'b1;
          cmd_o.c_waddr = sts_i.frd_idx;
          cmd_o.c_from_flash = 1'b1;
        end
        if (!issue && !pend_q) state_d = S_FIN;
      end
      S_WIPE: begin
        cmd_o.f_we = 1'b1;
        cmd_o.f_waddr = fee_pkg::fee_addr(tgt_q, cnt_off);
        cmd_o.f_src = fee_pkg::FS_ERASED;
        if (cnt_q == fee_pkg::CNT_W'(fee_pkg::PART_WORDS - 1)) begin
          cnt_d = '0;
          state_d = S_FIN;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_RWAIT: state_d = S_FIN;
      S_WCMP: begin
        if (sts_i.cache_eq) begin
          state_d = S_FIN;
        end else begin
          cmd_o.f_re = 1'b1;
          cmd_o.f_raddr = fee_pkg::fee_addr(sts_i.part,
                                            fee_pkg::PW_AW'(fee_pkg::PART_WORDS - 1));
          state_d = S_WLAST;
        end
      end
      S_WLAST: begin
        if (!sts_i.frd_erased) begin
          cmd_o.c_we = 1'b1;
          cmd_o.c_waddr = sts_i.addr_idx;
          op_d = OP_COMPACT;
          tgt_d = ~sts_i.part;
          cnt_d = '0;
          state_d = S_ERASE;
        end else begin
          cnt_d = fee_pkg::CNT_W'(fee_pkg::PART_WORDS - 2);
          pend_d = 1'b0;
          state_d = S_BSCAN;
        end
      end
      S_BSCAN: begin
        // Backward search for the highest programmed word above the mark.
        if ((pend_q && !sts_i.frd_erased) || cnt_q == '0) begin
          cmd_o.f_we = 1'b1;
          cmd_o.f_waddr = fee_pkg::fee_addr(sts_i.part,
              (pend_q && !sts_i.frd_erased) ? fee_pkg::PW_AW'(poff_q + 1'b1)
                                            : fee_pkg::PW_AW'(1));
          cmd_o.f_src = fee_pkg::FS_ITEM;
          cmd_o.c_we = 1'b1;
          cmd_o.c_waddr = sts_i.addr_idx;
          state_d = S_FIN;
        end else begin
          cmd_o.f_re = 1'b1;
          cmd_o.f_raddr = fee_pkg::fee_addr(sts_i.part, cnt_off);
          poff_d = cnt_off;
          pend_d = 1'b1;
          cnt_d = cnt_q - 1'b1;
        end
      end
      S_FIN: begin
        if (!ov_q || out_ready_i) begin
          cmd_o.res_ld = 1'b1;
          cmd_o.res_err = err_q;
          cmd_o.res_rd = rdsel_q;
          ov_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      op_q    <= OP_INIT;
      cnt_q   <= '0;
      poff_q  <= '0;
      tgt_q   <= 1'b0;
      pend_q  <= 1'b0;
      err_q   <= 1'b0;
      rdsel_q <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      cnt_q   <= cnt_d;
      poff_q  <= poff_d;
      tgt_q   <= tgt_d;
      pend_q  <= pend_d;
      err_q   <= err_d;
      rdsel_q <= rdsel_d;
      ov_q    <= ov_d;
    end
  end

  assign out_valid_o = ov_q;

  `FEE_ASSERT(a_one_item, (in_valid_i && in_ready_o) |=> !in_ready_o, "second word taken while busy")
  `FEE_ASSERT(a_no_idle_program, cmd_o.f_we |-> !in_ready_o, "flash programmed while idle")
  `FEE_ASSERT_ANY(a_rst_quiet, !rst_ni |=> (!in_ready_o && !out_valid_o), "handshake active in reset")

endmodule

// ===== hw/rtl/flash_eeprom_emulation.sv =====
// Flash EEPROM emulation of reads, writes, init and format; a write that finds the last
// word of the partition programmed compacts into the other partition. The result is valid
// in the same cycle in which the next word can be accepted. One word is in flight at a time,
// over a single flash port. After reset a clearing pass erases the flash store and no word
// is taken until it ends; cache, flags and result valid clear at once. Depends on fee_pkg,
// fee_ctrl and fee_datapath.
module flash_eeprom_emulation (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  mode_i,
  input  logic [15:0] address_i,
  input  logic [15:0] write_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] read_data_o,
  output logic        status_o,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i
);

  // The controller sequences every command over the flash and cache ports;
  // the datapath owns the storage and the result register, which holds a
  // finished word until the consumer takes it.
  fee_pkg::cmd_t cmd;
  fee_pkg::sts_t sts;

  fee_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  fee_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .mode_i       (mode_i),
    .address_i    (address_i),
    .write_data_i (write_data_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .read_data_o  (read_data_o),
    .status_o     (status_o)
  );

endmodule
